// ===== rtl/core/utf8_validate_and_repair_macros.svh =====
// ----------------------------------------------------------------------------
// UTF-8 validate and repair: assertion macros
// Shared concurrent assertion forms for the repair datapath.
// ----------------------------------------------------------------------------
`ifndef UTF8_VALIDATE_AND_REPAIR_MACROS_SVH
`define UTF8_VALIDATE_AND_REPAIR_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define UTF8VR_ASSERT_IMPL(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define UTF8VR_ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/utf8vr_pkg.sv =====
// ----------------------------------------------------------------------------
// UTF-8 validate and repair: package
// Shared types, byte-class masks and the replacement character encoding.
// ----------------------------------------------------------------------------
package utf8vr_pkg;

    localparam int unsigned HELD_DEPTH = 3;
    localparam int unsigned MAX_TOKENS = 4;

    localparam logic [7:0] ASCII_MAX   = 8'h7F;
    localparam logic [7:0] MASK_2BIT   = 8'hC0;
    localparam logic [7:0] MASK_3BIT   = 8'hE0;
    localparam logic [7:0] MASK_4BIT   = 8'hF0;
    localparam logic [7:0] MASK_5BIT   = 8'hF8;
    localparam logic [7:0] CONT_CODE   = 8'h80;
    localparam logic [7:0] LEAD2_CODE  = 8'hC0;
    localparam logic [7:0] LEAD3_CODE  = 8'hE0;
    localparam logic [7:0] LEAD4_CODE  = 8'hF0;

    // U+FFFD encoded as UTF-8
    localparam logic [7:0] REPL_BYTE0  = 8'hEF;
    localparam logic [7:0] REPL_BYTE1  = 8'hBF;
    localparam logic [7:0] REPL_BYTE2  = 8'hBD;

    localparam logic [1:0] SUB_FIRST   = 2'd0;
    localparam logic [1:0] SUB_SECOND  = 2'd1;
    localparam logic [1:0] SUB_THIRD   = 2'd2;

    // One output unit: a literal byte or a full replacement character
    typedef struct packed {
        logic       repl;
        logic [7:0] data;
    } tok_t;

    // All output units caused by one input byte
    typedef struct packed {
        tok_t [MAX_TOKENS-1:0] tok;
        logic [2:0]            ntok;
        logic                  text_end;
    } burst_t;

    function automatic logic [7:0] repl_byte(input logic [1:0] sub);
        logic [7:0] res;
        case (sub)
            SUB_FIRST:  res = REPL_BYTE0;
            SUB_SECOND: res = REPL_BYTE1;
            SUB_THIRD:  res = REPL_BYTE2;
            default:    res = REPL_BYTE2;
        endcase
        return res;
    endfunction

endpackage

// ===== rtl/core/utf8_validate_and_repair.sv =====
// ----------------------------------------------------------------------------
// UTF-8 validate and repair: top level
// Repair a UTF-8 byte stream, replacing every bad byte with U+FFFD.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*) carries the input text one byte per transaction;
//   s_tlast marks the last byte of a text. Master channel (m_*) carries the
//   repaired text one byte per transaction; m_tuser[0] marks the last byte
//   caused by one input transaction and m_tlast the last byte of the text.
//   Path: an input byte that yields output passes through the input
//   register, the burst register and the output register before it
//   appears on m_tdata. A lead or middle byte of a valid sequence is
//   held and comes out with the byte that completes it.
//   Throughput: one input transaction per cycle while each yields at most
//   one output byte and m_tready stays high. An input transaction that
//   yields N output bytes (up to twelve: three held bytes plus the new
//   one, each as a three-byte U+FFFD) occupies the emitter while they
//   leave one by one; the next input byte waits in the input register
//   and s_tready stays low meanwhile.
//   Reset clears the held byte count and need state and empties every stage.
//   When the receiver stalls (m_tready low) the output byte holds, the
//   emitter and input register fill, and s_tready drops.
// ----------------------------------------------------------------------------
`include "utf8_validate_and_repair_macros.svh"

module utf8_validate_and_repair
(
    input  logic        clk,
    input  logic        rst_n,
    // input byte stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] in_byte
    input  logic        s_tlast,   // in_end
    // repaired byte stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast,   // text_end
    output logic [0:0]  m_tuser    // [0] run_last
);

    logic               in_valid_reg;
    logic [7:0]         in_byte_reg;
    logic               in_end_reg;
    logic               burst_ready;
    logic               consume;
    utf8vr_pkg::burst_t burst;

    // Hand the registered byte to the scanner once the emitter can take its burst
    assign consume  = in_valid_reg && burst_ready;
    assign s_tready = !in_valid_reg || burst_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tvalid && s_tready)
            in_valid_reg <= 1'b1;
        else if (consume)
            in_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
            in_end_reg  <= s_tlast;
        end
    end

    // Classify the byte against held state and build its output burst
    utf8vr_scan u_scan
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_byte (in_byte_reg),
        .in_end  (in_end_reg),
        .take    (consume),
        .burst   (burst)
    );

    // Serialize bursts into the output register
    utf8vr_emit u_emit
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst       (burst),
        .load        (consume),
        .burst_ready (burst_ready),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser)
    );

    // End of text always closes a run
    `UTF8VR_ASSERT_IMPL(a_end_closes_run, clk, rst_n, m_tvalid && m_tlast, m_tuser[0], "text end without run end")
    // An end-of-text byte always yields output
    `UTF8VR_ASSERT_IMPL(a_end_yields, clk, rst_n, consume && in_end_reg, burst.ntok != 3'd0, "end of text produced no bytes")
    // Bytes of one run leave without gaps
    `UTF8VR_ASSERT_NEXT(a_run_contiguous, clk, rst_n, m_tvalid && m_tready && !m_tuser[0], m_tvalid, "gap inside a run")

endmodule

// ===== rtl/core/utf8vr_scan.sv =====
// ----------------------------------------------------------------------------
// UTF-8 validate and repair: scanner
// Hold partial sequences and turn each input byte into a burst of units.
// ----------------------------------------------------------------------------
module utf8vr_scan
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic [7:0]          in_byte,
    input  logic                in_end,
    input  logic                take,
    output utf8vr_pkg::burst_t  burst
);

    logic [7:0] held_bytes_reg [utf8vr_pkg::HELD_DEPTH];
    logic [1:0] held_count_reg;
    logic [1:0] held_count_next;
    logic [1:0] need_reg;
    logic [1:0] need_next;

    logic       is_cont;
    logic       is_ascii;
    logic [1:0] need_fresh;
    logic       held_any;
    logic       complete;
    logic       append;
    logic       fresh_hold;
    logic       fresh_repl;
    logic [2:0] cnt_ext;

    always_comb
    begin
        is_cont  = (in_byte & utf8vr_pkg::MASK_2BIT) == utf8vr_pkg::CONT_CODE;
        is_ascii = in_byte <= utf8vr_pkg::ASCII_MAX;
        if ((in_byte & utf8vr_pkg::MASK_3BIT) == utf8vr_pkg::LEAD2_CODE)
            need_fresh = 2'd1;
        else if ((in_byte & utf8vr_pkg::MASK_4BIT) == utf8vr_pkg::LEAD3_CODE)
            need_fresh = 2'd2;
        else if ((in_byte & utf8vr_pkg::MASK_5BIT) == utf8vr_pkg::LEAD4_CODE)
            need_fresh = 2'd3;
        else
            need_fresh = 2'd0;

        held_any   = held_count_reg != 2'd0;
        complete   = held_any && is_cont && need_reg == 2'd1;
        append     = held_any && is_cont && need_reg != 2'd1;
        fresh_hold = !(held_any && is_cont) && !is_ascii && need_fresh != 2'd0 && !in_end;
        fresh_repl = !(held_any && is_cont) && !is_ascii && !(need_fresh != 2'd0 && !in_end);
        cnt_ext    = {1'b0, held_count_reg};
    end

    // Build the burst: held units first, then the unit for the new byte
    always_comb
    begin
        for (int i = 0; i < utf8vr_pkg::MAX_TOKENS; i++)
        begin
            if (3'(i) < cnt_ext)
                burst.tok[i].data = held_bytes_reg[i[1:0]];
            else
                burst.tok[i].data = in_byte;
            if (append)
                burst.tok[i].repl = 1'b1;
            else if (complete)
                burst.tok[i].repl = 1'b0;
            else
                burst.tok[i].repl = (3'(i) < cnt_ext) || fresh_repl;
        end

        if (complete)
            burst.ntok = cnt_ext + 3'd1;
        else if (append)
            burst.ntok = in_end ? cnt_ext + 3'd1 : 3'd0;
        else
            burst.ntok = cnt_ext + (fresh_hold ? 3'd0 : 3'd1);
        burst.text_end = in_end;
    end

    always_comb
    begin
        held_count_next = 2'd0;
        need_next       = 2'd0;
        if (append && !in_end)
        begin
            held_count_next = held_count_reg + 2'd1;
            need_next       = need_reg - 2'd1;
        end
        else if (fresh_hold)
        begin
            held_count_next = 2'd1;
            need_next       = need_fresh;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_count_reg <= 2'd0;
            need_reg       <= 2'd0;
        end
        else if (take)
        begin
            held_count_reg <= held_count_next;
            need_reg       <= need_next;
        end
    end

    // Held byte storage, no reset: only entries below the count are read
    always_ff @(posedge clk)
    begin
        if (take && append && !in_end)
            held_bytes_reg[held_count_reg] <= in_byte;
        else if (take && fresh_hold)
            held_bytes_reg[0] <= in_byte;
    end

endmodule

// ===== rtl/core/utf8vr_emit.sv =====
// ----------------------------------------------------------------------------
// UTF-8 validate and repair: emitter
// Walk a burst one byte per cycle into the output register while m_tready allows.
// ----------------------------------------------------------------------------
module utf8vr_emit
(
    input  logic                clk,
    input  logic                rst_n,
    input  utf8vr_pkg::burst_t  burst,
    input  logic                load,
    output logic                burst_ready,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [7:0]          m_tdata,
    output logic                m_tlast,
    output logic [0:0]          m_tuser
);

    utf8vr_pkg::burst_t burst_reg;
    logic               busy_reg;
    logic [1:0]         tok_idx_reg;
    logic [1:0]         sub_idx_reg;
    logic               out_valid_reg;
    logic [7:0]         out_byte_reg;
    logic               out_run_last_reg;
    logic               out_text_end_reg;

    utf8vr_pkg::tok_t   cur_tok;
    logic [7:0]         cur_byte;
    logic               tok_last;
    logic               burst_last;
    logic               advance;

    always_comb
    begin
        cur_tok    = burst_reg.tok[tok_idx_reg];
        cur_byte   = cur_tok.repl ? utf8vr_pkg::repl_byte(sub_idx_reg) : cur_tok.data;
        tok_last   = !cur_tok.repl || sub_idx_reg == utf8vr_pkg::SUB_THIRD;
        burst_last = tok_last && ({1'b0, tok_idx_reg} == burst_reg.ntok - 3'd1);
        advance    = busy_reg && (!out_valid_reg || m_tready);
        burst_ready = !busy_reg || (advance && burst_last);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg      <= 1'b0;
            tok_idx_reg   <= 2'd0;
            sub_idx_reg   <= utf8vr_pkg::SUB_FIRST;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (load && burst.ntok != 3'd0)
            begin
                busy_reg    <= 1'b1;
                tok_idx_reg <= 2'd0;
                sub_idx_reg <= utf8vr_pkg::SUB_FIRST;
            end
            else if (advance)
            begin
                if (burst_last)
                    busy_reg <= 1'b0;
                if (tok_last)
                begin
                    tok_idx_reg <= tok_idx_reg + 2'd1;
                    sub_idx_reg <= utf8vr_pkg::SUB_FIRST;
                end
                else
                    sub_idx_reg <= sub_idx_reg + 2'd1;
            end

            if (advance)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
            burst_reg <= burst;
        if (advance)
        begin
            out_byte_reg     <= cur_byte;
            out_run_last_reg <= burst_last;
            out_text_end_reg <= burst_last && burst_reg.text_end;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tlast    = out_text_end_reg;
    assign m_tuser[0] = out_run_last_reg;

endmodule
